/* sv/top_k_threshold_selector_top_defines.svh */
// assertion macros for the top-k threshold selector checker
// no dependencies
`ifndef TOP_K_THRESHOLD_SELECTOR_TOP_DEFINES_SVH
`define TOP_K_THRESHOLD_SELECTOR_TOP_DEFINES_SVH

// same-cycle implication, reset disables
`define TKTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables
`define TKTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/tkts_pkg.sv */
// shared types, constants and helpers of the top-k threshold selector
// no dependencies
`timescale 1ns / 1ps

package tkts_pkg;

	localparam int PROB_W    = 17;
	localparam int TAG_W     = 32;
	localparam int OP_W      = 2;
	localparam int SLOT_W    = 4;
	localparam int SLOTS_DEF = 16;
	localparam int MAX_READ  = 16;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 2;

	localparam logic [PROB_W-1:0]  ONE_Q16          = 17'h10000;
	localparam logic [PADDR_W-1:0] ADDR_MIN_OCC     = 2'd0;

	localparam logic [OP_W-1:0] OP_OFFER = 2'd0;
	localparam logic [OP_W-1:0] OP_READ  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic [PROB_W-1:0] key;
		logic [PROB_W-1:0] occ;
		logic [TAG_W-1:0]  tag;
	} slot_rec_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} mem_ctl_t;

	function automatic logic [PROB_W-1:0] sat_q16(input logic [PROB_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

endpackage

/* sv/tkts_if.sv */
// item channel interfaces of the top-k threshold selector
// depends on tkts_pkg
`timescale 1ns / 1ps

interface tkts_in_if import tkts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [PROB_W-1:0] increase_prob;
	logic [PROB_W-1:0] occurrence_prob;
	logic [TAG_W-1:0]  tag;

	modport source (output valid, op, increase_prob, occurrence_prob, tag, input ready);
	modport sink (input valid, op, increase_prob, occurrence_prob, tag, output ready);
endinterface

interface tkts_out_if import tkts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [SLOT_W-1:0] slot;
	logic [PROB_W-1:0] out_increase_prob;
	logic [PROB_W-1:0] out_occurrence_prob;
	logic [TAG_W-1:0]  out_tag;
	logic              last;

	modport source (output valid, accepted, slot, out_increase_prob, out_occurrence_prob,
		out_tag, last, input ready);
	modport sink (input valid, accepted, slot, out_increase_prob, out_occurrence_prob,
		out_tag, last, output ready);
endinterface

/* sv/top_k_threshold_selector_top.sv */
// top level of the top-k threshold selector: sequencer, shared comparator, apb register
// depends on tkts_pkg, tkts_if, tkts_slot_mem
`timescale 1ns / 1ps

// Keeps the SLOTS records with the largest increase probability (unsigned Q1.16, 65536 = 1.0).
// op 0 offers a record: it is dropped if its occurrence is below min_occurrence, otherwise one
// comparator scans the slot memory for the first smallest key below 1.0 and the record replaces
// that slot when its key is larger; one result item with last set. op 1 reads out the first
// min(SLOTS,16) slots in order, last set on the final one. op 2 clears all slots at once with
// no result; op 3 is ignored. An offer reads the slots one by one through the single read port,
// then a drain state and a write state that loads the result; a dropped offer goes straight to
// the write state; a read alternates a read and an output state per slot. The input is not ready
// while an offer or a read is in progress; a finished result waits in the output register.
module top_k_threshold_selector_top import tkts_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	tkts_in_if.sink            item_in,
	tkts_out_if.source         item_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int NRD   = (SLOTS < MAX_READ) ? SLOTS : MAX_READ;
	localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SLOTS - 1);
	localparam logic [IDX_W-1:0] READ_LAST = IDX_W'(NRD - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_OFFER_DONE,
		S_RD_ADDR,
		S_RD_DATA
	} state_t;

	state_t            state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [PROB_W-1:0] min_occ_q;
	logic [PROB_W-1:0] key_q;
	logic [PROB_W-1:0] occ_q;
	logic [TAG_W-1:0]  tag_q;
	logic [PROB_W-1:0] least_q;
	logic [IDX_W-1:0]  pick_q;
	logic              found_q;
	logic              cmp_en_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;

	logic              out_valid_q;
	logic              out_accepted_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [PROB_W-1:0] out_inc_q;
	logic [PROB_W-1:0] out_occ_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic              out_last_q;

	logic              in_fire;
	logic              out_free;
	logic              out_load;
	logic              take;
	logic              cfg_wr;
	logic [PROB_W-1:0] in_key;
	logic [PROB_W-1:0] in_occ;
	mem_ctl_t          mem_ctl;
	slot_rec_t         wr_rec;
	slot_rec_t         rd_rec;

	assign item_in.ready = (state_q == S_IDLE);
	assign in_fire       = item_in.valid && item_in.ready;
	assign out_free      = !out_valid_q || item_out.ready;
	assign out_load      = out_free && ((state_q == S_OFFER_DONE) || (state_q == S_RD_DATA));
	assign in_key        = sat_q16(item_in.increase_prob);
	assign in_occ        = sat_q16(item_in.occurrence_prob);
	assign take          = found_q && (key_q > least_q);

	assign mem_ctl.rd_en = (state_q == S_SCAN) || (state_q == S_RD_ADDR);
	assign mem_ctl.wr_en = (state_q == S_OFFER_DONE) && out_free && take;
	assign mem_ctl.clr   = in_fire && (item_in.op == OP_CLEAR);
	assign wr_rec        = '{key: key_q, occ: occ_q, tag: tag_q};

	tkts_slot_mem #(
		.SLOTS(SLOTS)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_addr (pick_q),
		.wr_data (wr_rec),
		.rd_addr (idx_q),
		.rd_data (rd_rec)
	);

	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MIN_OCC);
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MIN_OCC) ? PDATA_W'(min_occ_q) : '0;

	assign item_out.valid               = out_valid_q;
	assign item_out.accepted            = out_accepted_q;
	assign item_out.slot                = out_slot_q;
	assign item_out.out_increase_prob   = out_inc_q;
	assign item_out.out_occurrence_prob = out_occ_q;
	assign item_out.out_tag             = out_tag_q;
	assign item_out.last                = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			min_occ_q   <= '0;
			found_q     <= 1'b0;
			cmp_en_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				min_occ_q <= pwdata[PROB_W-1:0];
			end
			if (out_valid_q && item_out.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			// shared comparator, one slot per cycle
			cmp_en_s1  <= (state_q == S_SCAN);
			cmp_idx_s1 <= idx_q;
			if (cmp_en_s1 && (rd_rec.key < least_q)) begin
				least_q <= rd_rec.key;
				pick_q  <= cmp_idx_s1;
				found_q <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						case (item_in.op)
							OP_OFFER: begin
								key_q   <= in_key;
								occ_q   <= in_occ;
								tag_q   <= item_in.tag;
								least_q <= ONE_Q16;
								found_q <= 1'b0;
								if (in_occ < sat_q16(min_occ_q)) begin
									state_q <= S_OFFER_DONE;
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_READ: begin
								state_q <= S_RD_ADDR;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == SCAN_LAST) begin
						state_q <= S_SCAN_END;
					end
				end
				S_SCAN_END: begin
					state_q <= S_OFFER_DONE;
				end
				S_OFFER_DONE: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_accepted_q <= take;
						out_slot_q     <= take ? SLOT_W'(pick_q) : '0;
						out_inc_q      <= '0;
						out_occ_q      <= '0;
						out_tag_q      <= '0;
						out_last_q     <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				S_RD_ADDR: begin
					state_q <= S_RD_DATA;
				end
				S_RD_DATA: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						out_accepted_q <= 1'b0;
						out_slot_q     <= SLOT_W'(idx_q);
						out_inc_q      <= rd_rec.key;
						out_occ_q      <= rd_rec.occ;
						out_tag_q      <= rd_rec.tag;
						out_last_q     <= (idx_q == READ_LAST);
						if (idx_q == READ_LAST) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD_ADDR;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/tkts_slot_mem.sv */
// slot record memory with per-entry valid bits and registered read
// depends on tkts_pkg
`timescale 1ns / 1ps

module tkts_slot_mem import tkts_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mem_ctl_t         ctl,
	input  logic [IDX_W-1:0] wr_addr,
	input  slot_rec_t        wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output slot_rec_t        rd_data
);

	slot_rec_t        mem_q [SLOTS];
	slot_rec_t        rd_rec_q;
	logic             rd_vld_q;
	logic [SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_rec_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctl.clr) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// slots not written since reset or the last clear read as zero
	assign rd_data = rd_vld_q ? rd_rec_q : '0;

endmodule

/* sv/tkts_checker.sv */
// port-level checker of the top-k threshold selector, bound to the top level
// depends on tkts_pkg, top_k_threshold_selector_top_defines.svh, top_k_threshold_selector_top
`timescale 1ns / 1ps
`include "top_k_threshold_selector_top_defines.svh"

module tkts_checker import tkts_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [OP_W-1:0]   in_op,
	input logic              out_valid,
	input logic              out_ready,
	input logic              out_accepted,
	input logic [SLOT_W-1:0] out_slot,
	input logic [PROB_W-1:0] out_inc,
	input logic [TAG_W-1:0]  out_tag,
	input logic              out_last
);

	`TKTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result item dropped while stalled")
	`TKTS_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_slot) && $stable(out_tag) && $stable(out_last), "result item changed while stalled")
	`TKTS_ASSERT_IMP(a_acc_shape, clk, arst_n, out_valid && out_accepted, out_last && (out_inc == '0) && (out_tag == '0), "accepted offer result malformed")
	`TKTS_ASSERT_NXT(a_busy, clk, arst_n, in_valid && in_ready && (in_op == OP_OFFER || in_op == OP_READ), !in_ready, "input ready during offer or read")

endmodule

bind top_k_threshold_selector_top tkts_checker u_tkts_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item_in.valid),
	.in_ready     (item_in.ready),
	.in_op        (item_in.op),
	.out_valid    (item_out.valid),
	.out_ready    (item_out.ready),
	.out_accepted (item_out.accepted),
	.out_slot     (item_out.slot),
	.out_inc      (item_out.out_increase_prob),
	.out_tag      (item_out.out_tag),
	.out_last     (item_out.last)
);

/* bench/tb_top.sv */
// testbench of the top-k threshold selector: directed table, then random items over four
// handshake phases, every result checked against a local top-k predictor
// depends on tkts_pkg, tkts_if, top_k_threshold_selector_top
`timescale 1ns / 1ps

module tb_top;
	import tkts_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int READ_COUNT = (SLOTS_DEF < MAX_READ) ? SLOTS_DEF : MAX_READ;
	localparam int NO_CFG = -1;
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASE_ITEMS = 26;
	localparam int NUM_ROWS = 16;

	typedef struct packed {
		logic              accepted;
		logic [SLOT_W-1:0] slot;
		logic [PROB_W-1:0] inc;
		logic [PROB_W-1:0] occ;
		logic [TAG_W-1:0]  tag;
		logic              last;
	} slot_result_t;

	typedef struct {
		int                min_set;
		logic [OP_W-1:0]   op;
		logic [PROB_W-1:0] inc;
		logic [PROB_W-1:0] occ;
		logic [TAG_W-1:0]  tag;
		bit                typed;
		bit                t_acc;
		logic [SLOT_W-1:0] t_slot;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	tkts_in_if  in_ch ();
	tkts_out_if out_ch ();

	top_k_threshold_selector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(in_ch),
		.item_out(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor state
	logic [PROB_W-1:0] key_mem [SLOTS_DEF];
	logic [PROB_W-1:0] occ_mem [SLOTS_DEF];
	logic [TAG_W-1:0]  tag_mem [SLOTS_DEF];
	logic [PROB_W-1:0] min_occ;

	slot_result_t due_results [$];
	int mismatch_count;
	int send_idle_pct;
	int recv_stall_pct;

	// 16 rows; typed expectations only where obvious
	stim_row_t directed_rows [NUM_ROWS] = '{
		'{NO_CFG,  OP_READ,   17'h00000, 17'h00000, 32'h00000000, 0, 0, 4'd0},
		'{NO_CFG,  OP_OFFER,  17'h00000, 17'h00000, 32'h00000000, 1, 0, 4'd0},
		'{NO_CFG,  OP_OFFER,  17'h10000, 17'h10000, 32'hffffffff, 1, 1, 4'd0},
		'{NO_CFG,  OP_OFFER,  17'h1ffff, 17'h1ffff, 32'h00000000, 1, 1, 4'd1},
		'{NO_CFG,  OP_OFFER,  17'h00001, 17'h00001, 32'h12345678, 1, 1, 4'd2},
		'{NO_CFG,  OP_OFFER,  17'h0ffff, 17'h10001, 32'ha5a5a5a5, 1, 1, 4'd3},
		'{NO_CFG,  OP_READ,   17'h00000, 17'h00000, 32'h00000000, 0, 0, 4'd0},
		'{NO_CFG,  OP_CLEAR,  17'h1ffff, 17'h1ffff, 32'hffffffff, 0, 0, 4'd0},
		'{NO_CFG,  OP_READ,   17'h00000, 17'h00000, 32'h00000000, 0, 0, 4'd0},
		'{NO_CFG,  OP_UNUSED, 17'h1ffff, 17'h1ffff, 32'hffffffff, 0, 0, 4'd0},
		'{NO_CFG,  OP_READ,   17'h00000, 17'h00000, 32'h00000000, 0, 0, 4'd0},
		'{65536,   OP_OFFER,  17'h00032, 17'h0ffff, 32'h0badf00d, 1, 0, 4'd0},
		'{NO_CFG,  OP_OFFER,  17'h00032, 17'h10000, 32'hc0ffee00, 1, 1, 4'd0},
		'{131071,  OP_OFFER,  17'h0003c, 17'h1ffff, 32'h5a5a5a5a, 1, 1, 4'd1},
		'{NO_CFG,  OP_OFFER,  17'h0003c, 17'h0ffff, 32'h87654321, 1, 0, 4'd0},
		'{0,       OP_READ,   17'h00000, 17'h00000, 32'h00000000, 0, 0, 4'd0}
	};

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	function automatic logic [PROB_W-1:0] clip_q16(input logic [PROB_W-1:0] v);
		return (v > ONE_Q16) ? ONE_Q16 : v;
	endfunction

	function automatic logic [PROB_W-1:0] rand_prob();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_Q16;
			2: return PROB_W'($urandom_range(65537, 131071));
			3: return PROB_W'($urandom_range(1, 15));
			default: return PROB_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic [OP_W-1:0] rand_op();
		int pct;
		pct = $urandom_range(0, 99);
		if (pct < 4)
			return OP_CLEAR;
		else if (pct < 7)
			return OP_UNUSED;
		else if (pct < 15)
			return OP_READ;
		else
			return OP_OFFER;
	endfunction

	// appends one expected result item at the tail
	function automatic void queue_result(input slot_result_t r);
		due_results.insert(due_results.size(), r);
	endfunction

	// applies one accepted item to the local slot copy and queues its results
	function automatic void update_topk(input logic [OP_W-1:0] op,
		input logic [PROB_W-1:0] inc, input logic [PROB_W-1:0] occ,
		input logic [TAG_W-1:0] tag);
		logic [PROB_W-1:0] k;
		logic [PROB_W-1:0] o;
		logic [PROB_W-1:0] least;
		int pick;
		bit found;
		slot_result_t r;
		case (op)
			OP_OFFER: begin
				k = clip_q16(inc);
				o = clip_q16(occ);
				r = '0;
				r.last = 1'b1;
				if (o >= clip_q16(min_occ)) begin
					least = ONE_Q16;
					found = 0;
					pick = 0;
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (key_mem[i] < least) begin
							least = key_mem[i];
							pick = i;
							found = 1;
						end
					end
					if (found && k > least) begin
						key_mem[pick] = k;
						occ_mem[pick] = o;
						tag_mem[pick] = tag;
						r.accepted = 1'b1;
						r.slot = SLOT_W'(pick);
					end
				end
				queue_result(r);
			end
			OP_READ: begin
				for (int i = 0; i < READ_COUNT; i++) begin
					r.accepted = 1'b0;
					r.slot = SLOT_W'(i);
					r.inc = key_mem[i];
					r.occ = occ_mem[i];
					r.tag = tag_mem[i];
					r.last = (i == READ_COUNT - 1);
					queue_result(r);
				end
			end
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS_DEF; i++) begin
					key_mem[i] = '0;
					occ_mem[i] = '0;
					tag_mem[i] = '0;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(input logic [OP_W-1:0] op, input logic [PROB_W-1:0] inc,
		input logic [PROB_W-1:0] occ, input logic [TAG_W-1:0] tag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.increase_prob <= inc;
		in_ch.occurrence_prob <= occ;
		in_ch.tag <= tag;
		do @(posedge clk); while (!in_ch.ready);
		update_topk(op, inc, occ, tag);
	endtask

	// sender holds off until every queued result is out and the block has gone quiet
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_occ(input logic [PROB_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MIN_OCC;
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		min_occ = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [TAG_W-1:0] want,
		input logic [TAG_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		slot_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual slot %0h last %0h",
					$time, out_ch.slot, out_ch.last);
				mismatch_count++;
			end else begin
				want = due_results.pop_front();
				check_field("accepted", want.accepted, out_ch.accepted);
				check_field("slot", want.slot, out_ch.slot);
				check_field("out_increase_prob", want.inc, out_ch.out_increase_prob);
				check_field("out_occurrence_prob", want.occ, out_ch.out_occurrence_prob);
				check_field("out_tag", want.tag, out_ch.out_tag);
				check_field("last", want.last, out_ch.last);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [PROB_W-1:0] cfg;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_OFFER;
		in_ch.increase_prob = '0;
		in_ch.occurrence_prob = '0;
		in_ch.tag = '0;
		out_ch.ready = 1'b0;
		mismatch_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		min_occ = '0;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			key_mem[i] = '0;
			occ_mem[i] = '0;
			tag_mem[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].min_set != NO_CFG) begin
				settle();
				write_min_occ(PROB_W'(directed_rows[n].min_set));
			end
			send_item(directed_rows[n].op, directed_rows[n].inc, directed_rows[n].occ,
				directed_rows[n].tag);
			if (directed_rows[n].typed) begin
				due_results[due_results.size() - 1].accepted = directed_rows[n].t_acc;
				due_results[due_results.size() - 1].slot = directed_rows[n].t_slot;
			end
		end

		for (int phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					cfg = '0;
				end
				1: begin
					send_idle_pct = 60;
					recv_stall_pct = 0;
					cfg = PROB_W'($urandom_range(0, 65536));
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 60;
					cfg = 17'h1ffff;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
					cfg = PROB_W'($urandom_range(0, 131071));
				end
			endcase
			write_min_occ(cfg);
			// fill every slot with 1.0, then offers that must be refused
			for (int i = 0; i <= SLOTS_DEF; i++)
				send_item(OP_OFFER, ($urandom_range(0, 3) == 0) ? 17'h1ffff : ONE_Q16,
					17'h1ffff, $urandom());
			send_item(OP_READ, rand_prob(), rand_prob(), $urandom());
			send_item(OP_OFFER, rand_prob(), 17'h1ffff, $urandom());
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(rand_op(), rand_prob(), rand_prob(), $urandom());
		end

		in_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/tkts_pkg.sv
sv/tkts_if.sv
sv/tkts_slot_mem.sv
sv/top_k_threshold_selector_top.sv
sv/tkts_checker.sv
bench/tb_top.sv
